>>> sv/cbe_pkg.sv
// ----------------------------------------------------------------------------
// cbe_pkg - shared definitions for the clap burst envelope
// Widths, envelope constants, register indexes and item codes used by the
// channel interfaces and the envelope datapath.
// ----------------------------------------------------------------------------
package cbe_pkg;

  // field widths
  localparam int unsigned LEVEL_W  = 31;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned STEP_W   = 31;

  // envelope constants
  localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 31'h7FFF_0000;
  localparam logic [LEVEL_W-1:0] LEVEL_FLOOR = 31'h0000_FFFF;
  localparam logic [LEVEL_W-1:0] LEVEL_ZERO  = '0;

  // register reset values
  localparam logic [STEP_W-1:0] BURST_RESET = 31'd4869428;
  localparam logic [STEP_W-1:0] DECAY_RESET = 31'd486942;

  // default number of short burst phases
  localparam int unsigned BURST_PHASES_DEF = 3;

  // shift-add multiplier: multiplier bits per product, accumulator halves
  localparam int unsigned MUL_BITS = 15;
  localparam int unsigned MUL_HI_W = 17;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_BITS);

  // configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic REG_BURST_STEP = 1'b0;
  localparam logic REG_DECAY_STEP = 1'b1;

  // item kinds
  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_TRIGGER = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [LEVEL_W-1:0]  level_t;
  typedef logic        [STEP_W-1:0]   step_t;

endpackage

>>> sv/cbe_if.sv
// ----------------------------------------------------------------------------
// cbe_if - item channels of the clap burst envelope
// Valid/ready channels for incoming items (samples and triggers) and for
// shaped samples.
// ----------------------------------------------------------------------------

// incoming item channel
interface cbe_in_if;
  logic             valid;
  logic             ready;
  logic             kind;
  cbe_pkg::sample_t sample_in;

  modport source (output valid, output kind, output sample_in, input ready);
  modport sink   (input valid, input kind, input sample_in, output ready);
endinterface

// shaped sample channel
interface cbe_out_if;
  logic             valid;
  logic             ready;
  cbe_pkg::sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

>>> sv/clap_burst_envelope.sv
// ----------------------------------------------------------------------------
// clap_burst_envelope - multi-burst decay envelope for a clap voice
// Steps a level/phase envelope per audio item and scales the sample by the
// squared level, using one bit-serial shift-add multiplier.
// ----------------------------------------------------------------------------
// A trigger item is taken and yields no output. An audio item that falls in
// silence goes to the output stage and yields a zero. Any other audio item
// is handled in steps: the envelope is stepped, the level's 15 top bits are
// squared and then the sample is scaled, both on the same 17-bit shift-add
// unit that retires one multiplier bit per cycle, and the result is handed to
// the output register once that is free. A new item is taken once the previous
// one has left the datapath; the output register lets it enter while a shaped
// sample is still waiting downstream. Step registers are at byte 0 (burst) and
// byte 4 (decay) and must only be written while the block is idle.
module clap_burst_envelope #(
  parameter int unsigned BURST_PHASES = cbe_pkg::BURST_PHASES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  cbe_in_if.sink                       in_i,
  cbe_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cbe_pkg::PADDR_W-1:0]  paddr,
  input  logic [cbe_pkg::PDATA_W-1:0]  pwdata,
  output logic [cbe_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int unsigned PH_W = $clog2(BURST_PHASES + 1);
  localparam logic [PH_W-1:0] LAST_PHASE = PH_W'(BURST_PHASES);
  localparam int unsigned HI_W = cbe_pkg::MUL_HI_W;
  localparam int unsigned LO_W = cbe_pkg::MUL_BITS;
  localparam int unsigned CNT_W = cbe_pkg::MUL_CNT_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(cbe_pkg::MUL_BITS - 1);

  // sequencer codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQR  = 2'd1;
  localparam logic [1:0] ST_SCL  = 2'd2;
  localparam logic [1:0] ST_WAIT = 2'd3;

  logic [1:0]                  state_q, state_d;
  cbe_pkg::step_t              burst_q, decay_q;
  cbe_pkg::level_t             level_q, level_d;
  logic [PH_W-1:0]             phase_q, phase_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;
  cbe_pkg::sample_t            out_q, out_d;
  cbe_pkg::sample_t            res_q, res_d;
  cbe_pkg::sample_t            samp_q, samp_d;
  logic [LO_W-1:0]             t_q, t_d;
  logic [HI_W+LO_W-1:0]        acc_q, acc_d;

  cbe_pkg::step_t              step;
  logic                        in_burst;
  logic                        silent;
  logic                        short_lvl;
  cbe_pkg::level_t             lvl_sub;
  logic                        take;
  logic                        cfg_wr;
  logic [HI_W-1:0]             mcand;
  logic [HI_W-1:0]             sum;
  logic [HI_W+LO_W-1:0]        acc_nxt;
  logic                        out_free;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == cbe_pkg::REG_DECAY_STEP) ? {1'b0, decay_q} : {1'b0, burst_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q <= cbe_pkg::BURST_RESET;
      decay_q <= cbe_pkg::DECAY_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == cbe_pkg::REG_DECAY_STEP) begin
        decay_q <= pwdata[cbe_pkg::STEP_W-1:0];
      end else begin
        burst_q <= pwdata[cbe_pkg::STEP_W-1:0];
      end
    end
  end

  // envelope step decision
  assign in_burst  = phase_q < LAST_PHASE;
  assign step      = in_burst ? burst_q : decay_q;
  assign silent    = level_q < cbe_pkg::LEVEL_FLOOR;
  assign short_lvl = level_q < step;
  assign lvl_sub   = level_q - step;

  assign in_i.ready = (state_q == ST_IDLE);
  assign take       = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // shared shift-add unit, one multiplier bit per cycle
  assign mcand   = (state_q == ST_SCL) ? {samp_q[cbe_pkg::SAMPLE_W-1], samp_q}
                                       : {{(HI_W-LO_W){1'b0}}, t_q};
  assign sum     = acc_q[HI_W+LO_W-1:LO_W] + (acc_q[0] ? mcand : '0);
  assign acc_nxt = {sum[HI_W-1], sum, acc_q[LO_W-1:1]};

  // sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    level_d     = level_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    samp_d      = samp_q;
    t_d         = t_q;
    acc_d       = acc_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;

    case (state_q)
      ST_IDLE: begin
        if (take) begin
          samp_d = in_i.sample_in;
          if (in_i.kind == cbe_pkg::KIND_TRIGGER) begin
            level_d = cbe_pkg::LEVEL_FULL;
            phase_d = '0;
          end else if (silent) begin
            res_d   = '0;
            state_d = ST_WAIT;
          end else if (short_lvl && !in_burst) begin
            // end of the final decay: fall silent
            level_d = cbe_pkg::LEVEL_ZERO;
            res_d   = '0;
            state_d = ST_WAIT;
          end else begin
            if (short_lvl) begin
              // phase change: back to full level
              phase_d = phase_q + 1'b1;
              level_d = cbe_pkg::LEVEL_FULL;
              t_d     = cbe_pkg::LEVEL_FULL[LO_W+15:16];
              acc_d   = {{HI_W{1'b0}}, cbe_pkg::LEVEL_FULL[LO_W+15:16]};
            end else begin
              level_d = lvl_sub;
              t_d     = lvl_sub[LO_W+15:16];
              acc_d   = {{HI_W{1'b0}}, lvl_sub[LO_W+15:16]};
            end
            cnt_d   = '0;
            state_d = ST_SQR;
          end
        end
      end
      ST_SQR: begin
        if (cnt_q == CNT_LAST) begin
          // gain is the square, top 15 of its 30 bits
          acc_d   = {{HI_W{1'b0}}, acc_nxt[2*LO_W-1:LO_W]};
          cnt_d   = '0;
          state_d = ST_SCL;
        end else begin
          acc_d = acc_nxt;
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SCL: begin
        if (cnt_q == CNT_LAST) begin
          res_d   = acc_nxt[HI_W+LO_W-1:HI_W+LO_W-cbe_pkg::SAMPLE_W];
          state_d = ST_WAIT;
        end else begin
          acc_d = acc_nxt;
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      level_q     <= cbe_pkg::LEVEL_ZERO;
      phase_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    samp_q <= samp_d;
    t_q    <= t_d;
    acc_q  <= acc_d;
    out_q  <= out_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_q;

endmodule
